FILE: hdl/frame_gpu_utilization_monitor_assert.svh
// Assertion macros used by the frame GPU utilization monitor controller.
`ifndef FRAME_GPU_UTILIZATION_MONITOR_ASSERT_SVH
`define FRAME_GPU_UTILIZATION_MONITOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FGUM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fgum assertion failed");
`define FGUM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fgum assertion failed");
`else
`define FGUM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FGUM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/fgum_pkg.sv
// Package: shared types and constants of the frame GPU utilization monitor.
`timescale 1ns / 1ps
`default_nettype none
package fgum_pkg;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 24;
	localparam logic [CFG_IW-1:0] REG_TICK_PERIOD = 2'd0;
	localparam logic [CFG_IW-1:0] REG_VALID_BITS  = 2'd1;
	localparam logic [CFG_IW-1:0] REG_WINDOW_MS   = 2'd2;

	localparam logic [23:0] TICK_RESET   = 24'd65536;
	localparam logic [6:0]  VBITS_RESET  = 7'd64;
	localparam logic [15:0] WINDOW_RESET = 16'd500;

	localparam logic [47:0] NS48_MAX     = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] USAGE_MAX    = 16'd38400;
	localparam logic [31:0] FIRST_CPU_MS = 32'd16;
	localparam logic [13:0] CPU_SCALE    = 14'd10000;  // ms -> 100 x 10 us
	localparam logic [9:0]  GPU_SCALE    = 10'd1000;   // ns -> us

	localparam int NUM_W = 56;
	localparam int DEN_W = 46;
	localparam int CNT_W = 6;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_MLO, ST_MHI, ST_NS, ST_PWR, ST_PACC, ST_CHK,
		ST_DEN_U, ST_DIV_U, ST_DEN_G, ST_DIV_G, ST_FIN, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_READ, OP_MUL_LO, OP_MUL_HI, OP_NS, OP_PAIR_WR,
		OP_PRES_ACC, OP_DEN_U, OP_DEN_G, OP_DIV, OP_FIN, OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_pres;
		logic expire;
		logic div_last;
	} dp_stat_t;
endpackage
`default_nettype wire

FILE: hdl/fgum_dp.sv
// Datapath: config registers, slot ring, pair timing, window sums and shared divider.
`timescale 1ns / 1ps
`default_nettype none
module fgum_dp import fgum_pkg::*; #(
	parameter int SLOTS          = 16,
	parameter int PAIRS_PER_SLOT = 64,
	parameter int READ_LAG       = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	input  wire logic [167:0]      s_tdata,
	input  wire logic              s_tuser,
	input  wire dp_cmd_t           cmd,
	output dp_stat_t               st,
	output logic [55:0]            m_tdata,
	output logic                   m_tuser
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW = $clog2(PAIRS_PER_SLOT + 1);
	localparam int EW = 32 + PW + 48;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
	localparam logic [31:0] LAG = 32'(READ_LAG);
	localparam logic [PW-1:0] PAIR_CAP = PW'(PAIRS_PER_SLOT);

	typedef struct packed {
		logic [31:0]   owner;
		logic [PW-1:0] count;
		logic [47:0]   total;
	} slot_t;

	logic [23:0] tick_q;
	logic [6:0]  vbits_q;
	logic [15:0] win_q;

	logic [63:0] start_q, end_q;
	logic        sr_q, er_q, pres_q;
	logic [31:0] now_q;

	logic [31:0]   serial_q;
	logic [IW-1:0] wr_idx_q, rd_idx_q;
	logic [SLOTS-1:0] valid_q;
	slot_t mem [SLOTS];
	slot_t rd_q;

	logic [63:0] ticks_s1;
	logic        pos_s1;
	logic [55:0] plo_q, phi_q;
	logic [47:0] ns_q;
	logic        taken_q;

	logic [31:0] last_ms_q, ws_q, acc_cpu_q, acc_fr_q;
	logic        seen_q, expire_q, have_q;
	logic [47:0] acc_gpu_q;
	logic [DEN_W-1:0] den_q, rem_q;
	logic [NUM_W-1:0] num_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0] usage_q, sm_use_q;
	logic [31:0] sm_gus_q;

	// pair interval, masked and wrap-corrected
	logic        masked;
	logic [63:0] mask, sm, em;
	logic [64:0] diff;
	logic [63:0] ticks_c;
	logic        pos_c;
	always_comb begin
		masked = (vbits_q >= 7'd1) && (vbits_q <= 7'd63);
		mask = masked ? ((64'd1 << vbits_q[5:0]) - 64'd1) : {64{1'b1}};
		sm = start_q & mask;
		em = end_q & mask;
		diff = {1'b0, em} - {1'b0, sm};
		if (masked && diff[64]) begin
			ticks_c = diff[63:0] + (64'd1 << vbits_q[5:0]);
			pos_c = 1'b1;
		end else begin
			ticks_c = diff[63:0];
			pos_c = !diff[64] && (diff[63:0] != 64'd0);
		end
	end

	logic [48:0] ns_sum;
	logic [47:0] ns_c;
	always_comb begin
		ns_sum = {1'b0, phi_q[31:0], 16'd0} + 49'(plo_q[55:16]);
		if (|phi_q[55:32] || ns_sum[48])
			ns_c = NS48_MAX;
		else
			ns_c = ns_sum[47:0];
	end

	// slot decision for a pair
	logic        cur_valid, hit, busy, full, take;
	logic [31:0] age;
	logic [PW-1:0] base_cnt;
	logic [47:0]   base_tot;
	logic [48:0]   tot_sum;
	slot_t         wr_ent;
	always_comb begin
		cur_valid = valid_q[wr_idx_q];
		hit = cur_valid && (rd_q.owner == serial_q);
		age = (serial_q > rd_q.owner) ? (serial_q - rd_q.owner) : 32'hFFFF_FFFF;
		busy = !hit && cur_valid && (age < LAG);
		base_cnt = hit ? rd_q.count : '0;
		base_tot = hit ? rd_q.total : 48'd0;
		full = (base_cnt == PAIR_CAP);
		take = !busy && !full;
		tot_sum = {1'b0, base_tot} + {1'b0, ns_q};
		wr_ent.owner = serial_q;
		wr_ent.count = base_cnt + PW'(1);
		wr_ent.total = tot_sum[48] ? NS48_MAX : tot_sum[47:0];
	end

	// present bookkeeping
	logic [31:0] dt, cpu_c, ws_eff, elapsed, rs;
	logic        rd_hit;
	logic [47:0] gpu_c;
	logic [32:0] cpu_sum;
	logic [48:0] gpu_sum;
	logic        expire_c;
	always_comb begin
		dt = now_q - last_ms_q;
		if (!seen_q)
			cpu_c = FIRST_CPU_MS;
		else if (dt == 32'd0 || dt[31])
			cpu_c = 32'd1;
		else
			cpu_c = dt;
		ws_eff = seen_q ? ws_q : now_q;
		rs = serial_q - LAG;
		rd_hit = (serial_q >= LAG) && valid_q[rd_idx_q] && (rd_q.owner == rs);
		gpu_c = rd_hit ? rd_q.total : 48'd0;
		cpu_sum = {1'b0, acc_cpu_q} + {1'b0, cpu_c};
		gpu_sum = {1'b0, acc_gpu_q} + {1'b0, gpu_c};
		elapsed = now_q - ws_eff;
		expire_c = !elapsed[31] && (elapsed >= {16'd0, win_q});
	end

	// one restoring step of the shared divider
	logic [DEN_W+1:0] trial;
	always_comb begin
		trial = {1'b0, rem_q, num_q[NUM_W-1]} - {2'b00, den_q};
	end

	logic [16:0] use_avg;
	logic [32:0] gus_avg;
	logic [31:0] gus_c;
	always_comb begin
		gus_c = (|num_q[NUM_W-1:32]) ? 32'hFFFF_FFFF : num_q[31:0];
		use_avg = ({1'b0, sm_use_q} + {1'b0, usage_q}) >> 1;
		gus_avg = ({1'b0, sm_gus_q} + {1'b0, gus_c}) >> 1;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_READ)
			rd_q <= mem[pres_q ? rd_idx_q : wr_idx_q];
		if (cmd.op == OP_PAIR_WR && take)
			mem[wr_idx_q] <= wr_ent;
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				start_q <= s_tdata[63:0];
				end_q <= s_tdata[127:64];
				sr_q <= s_tdata[128];
				er_q <= s_tdata[129];
				now_q <= s_tdata[161:130];
				pres_q <= s_tuser;
			end
			OP_READ: begin
				ticks_s1 <= ticks_c;
				pos_s1 <= pos_c && sr_q && er_q && (tick_q != 24'd0);
			end
			OP_MUL_LO: plo_q <= 56'(ticks_s1[31:0]) * 56'(tick_q);
			OP_MUL_HI: phi_q <= 56'(ticks_s1[63:32]) * 56'(tick_q);
			OP_NS:     ns_q <= pos_s1 ? ns_c : 48'd0;
			OP_DEN_U: begin
				den_q <= DEN_W'({14'd0, acc_cpu_q} * 46'(CPU_SCALE));
				num_q <= {acc_gpu_q, 8'd0};
				rem_q <= '0;
			end
			OP_DEN_G: begin
				usage_q <= (num_q > NUM_W'(USAGE_MAX)) ? USAGE_MAX : num_q[15:0];
				den_q <= DEN_W'({10'd0, acc_fr_q} * 42'(GPU_SCALE));
				num_q <= NUM_W'(acc_gpu_q);
				rem_q <= '0;
			end
			OP_DIV: begin
				if (!trial[DEN_W+1]) begin
					rem_q <= trial[DEN_W-1:0];
					num_q <= {num_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DEN_W-2:0], num_q[NUM_W-1]};
					num_q <= {num_q[NUM_W-2:0], 1'b0};
				end
			end
			OP_OUT: begin
				m_tdata <= {7'd0, taken_q, sm_gus_q, sm_use_q};
				m_tuser <= have_q;
			end
			default: ;
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= TICK_RESET;
			vbits_q <= VBITS_RESET;
			win_q <= WINDOW_RESET;
			serial_q <= '0;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			valid_q <= '0;
			taken_q <= 1'b0;
			last_ms_q <= '0;
			seen_q <= 1'b0;
			ws_q <= '0;
			acc_cpu_q <= '0;
			acc_gpu_q <= '0;
			acc_fr_q <= '0;
			expire_q <= 1'b0;
			cnt_q <= '0;
			sm_use_q <= '0;
			sm_gus_q <= '0;
			have_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TICK_PERIOD: tick_q <= cfg_wdata;
					REG_VALID_BITS:  vbits_q <= cfg_wdata[6:0];
					REG_WINDOW_MS:   win_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_LOAD: taken_q <= 1'b0;
				OP_PAIR_WR: begin
					taken_q <= take;
					if (take)
						valid_q[wr_idx_q] <= 1'b1;
				end
				OP_PRES_ACC: begin
					last_ms_q <= now_q;
					seen_q <= 1'b1;
					ws_q <= ws_eff;
					acc_cpu_q <= cpu_sum[32] ? 32'hFFFF_FFFF : cpu_sum[31:0];
					acc_gpu_q <= gpu_sum[48] ? NS48_MAX : gpu_sum[47:0];
					if (acc_fr_q != 32'hFFFF_FFFF)
						acc_fr_q <= acc_fr_q + 32'd1;
					expire_q <= expire_c;
					if (rd_hit)
						valid_q[rd_idx_q] <= 1'b0;
					serial_q <= serial_q + 32'd1;
					// index tracks the true 32-bit serial mod SLOTS, also across wrap
					if (serial_q == 32'hFFFF_FFFF || wr_idx_q == LAST_IDX)
						wr_idx_q <= '0;
					else
						wr_idx_q <= wr_idx_q + IW'(1);
					if (serial_q + 32'd1 == LAG || rd_idx_q == LAST_IDX)
						rd_idx_q <= '0;
					else
						rd_idx_q <= rd_idx_q + IW'(1);
				end
				OP_DEN_U, OP_DEN_G: cnt_q <= '0;
				OP_DIV: cnt_q <= cnt_q + CNT_W'(1);
				OP_FIN: begin
					sm_use_q <= have_q ? use_avg[15:0] : usage_q;
					sm_gus_q <= have_q ? gus_avg[31:0] : gus_c;
					have_q <= 1'b1;
					acc_cpu_q <= '0;
					acc_gpu_q <= '0;
					acc_fr_q <= '0;
					ws_q <= now_q;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		st.is_pres = pres_q;
		st.expire = expire_q;
		st.div_last = (cnt_q == CNT_W'(NUM_W - 1));
	end
endmodule
`default_nettype wire

FILE: hdl/fgum_ctrl.sv
// Controller: sequencing state machine and stream handshakes.
`timescale 1ns / 1ps
`default_nettype none
`include "frame_gpu_utilization_monitor_assert.svh"
module fgum_ctrl import fgum_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	input  wire dp_stat_t st,
	output dp_cmd_t   cmd
);
	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_RD;
			ST_RD:    state_d = st.is_pres ? ST_PACC : ST_MLO;
			ST_MLO:   state_d = ST_MHI;
			ST_MHI:   state_d = ST_NS;
			ST_NS:    state_d = ST_PWR;
			ST_PWR:   state_d = ST_DONE;
			ST_PACC:  state_d = ST_CHK;
			ST_CHK:   state_d = st.expire ? ST_DEN_U : ST_DONE;
			ST_DEN_U: state_d = ST_DIV_U;
			ST_DIV_U: if (st.div_last) state_d = ST_DEN_G;
			ST_DEN_G: state_d = ST_DIV_G;
			ST_DIV_G: if (st.div_last) state_d = ST_FIN;
			ST_FIN:   state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		case (state_q)
			ST_IDLE:  if (s_tvalid) cmd.op = OP_LOAD;
			ST_RD:    cmd.op = OP_READ;
			ST_MLO:   cmd.op = OP_MUL_LO;
			ST_MHI:   cmd.op = OP_MUL_HI;
			ST_NS:    cmd.op = OP_NS;
			ST_PWR:   cmd.op = OP_PAIR_WR;
			ST_PACC:  cmd.op = OP_PRES_ACC;
			ST_DEN_U: cmd.op = OP_DEN_U;
			ST_DIV_U, ST_DIV_G: cmd.op = OP_DIV;
			ST_DEN_G: cmd.op = OP_DEN_G;
			ST_FIN:   cmd.op = OP_FIN;
			ST_DONE:  if (out_free) cmd.op = OP_OUT;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	`FGUM_ASSERT_NXT(a_accept_reads, clk, arst_n, s_tvalid && s_tready, state_q == ST_RD)
	`FGUM_ASSERT_NXT(a_div_to_gus, clk, arst_n, state_q == ST_DIV_U && st.div_last, state_q == ST_DEN_G)
	`FGUM_ASSERT_NXT(a_done_holds, clk, arst_n, state_q == ST_DONE && m_tvalid_q && !m_tready, state_q == ST_DONE)
endmodule
`default_nettype wire

FILE: hdl/frame_gpu_utilization_monitor.sv
// Channel  | Group                    | Fields (low bit up)
// s        | s_tvalid/s_tready/tdata  | start_stamp, end_stamp, start_ready, end_ready, now_ms
//          | s_tuser                  | cmd (0 pair, 1 present)
// m        | m_tvalid/m_tready/tdata  | usage_pct, gpu_time_us, pair_taken
//          | m_tuser                  | metrics_valid
// cfg      | cfg_we/cfg_index/wdata   | 0 tick_period, 1 valid_bits, 2 window_ms
// A pair request runs from accept to result through slot read, two 32x24 multiplies
// by the tick period, ns scaling and slot update.
// A present updates the window sums; when the window closes it also runs the
// one-bit-per-cycle restoring divider shared by usage and GPU-time averaging.
// One request at a time; a result waiting on m_tready holds the next one in its last step.
// Reset is asynchronous and takes effect at once; no memory sweep is needed.
`timescale 1ns / 1ps
`default_nettype none
module frame_gpu_utilization_monitor import fgum_pkg::*; #(
	parameter int SLOTS          = 16,
	parameter int PAIRS_PER_SLOT = 64,
	parameter int READ_LAG       = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [167:0]      s_tdata,  // start_stamp, end_stamp, start_ready, end_ready, now_ms
	input  wire logic              s_tuser,  // cmd
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [55:0]            m_tdata,  // usage_pct, gpu_time_us, pair_taken
	output logic                   m_tuser   // metrics_valid
);
	dp_cmd_t  cmd;
	dp_stat_t st;

	fgum_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	fgum_dp #(
		.SLOTS          (SLOTS),
		.PAIRS_PER_SLOT (PAIRS_PER_SLOT),
		.READ_LAG       (READ_LAG)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.st        (st),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);
endmodule
`default_nettype wire

FILE: verif/tb_frame_gpu_utilization_monitor.sv
// Testbench for the frame GPU utilization monitor: self-checking against an in-bench predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_frame_gpu_utilization_monitor import fgum_pkg::*; ();

	localparam int NSLOT = 16;
	localparam int NPAIR = 64;
	localparam int LAG = 3;

	typedef struct packed {
		logic        metrics;
		logic [15:0] usage;
		logic [31:0] gpu_us;
		logic        taken;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = REG_TICK_PERIOD;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [167:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic m_tuser;

	always #1 clk = ~clk;

	frame_gpu_utilization_monitor dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
		.m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// predictor state
	logic [23:0] tick_q;
	logic [6:0]  vbits_q;
	logic [15:0] win_q;
	logic [31:0] serial;
	logic        sv [NSLOT];
	logic [31:0] sown [NSLOT];
	logic [6:0]  scnt [NSLOT];
	logic [47:0] sns [NSLOT];
	logic [31:0] last_ms, win_start, cpu_sum, frame_sum;
	logic        seen, have;
	logic [47:0] gpu_sum;
	logic [15:0] sm_usage;
	logic [31:0] sm_gpu;

	result_t expected_q[$];
	int errors = 0;
	int send_idle = 0, recv_idle = 0;
	int sent = 0;

	function automatic logic [47:0] sat48(logic [48:0] s);
		return s[48] ? NS48_MAX : s[47:0];
	endfunction

	function automatic logic [47:0] stamp_ns(logic [63:0] s, logic [63:0] e,
		logic sr, logic er);
		logic [64:0] ee;
		logic [63:0] mask, d;
		logic [63:0] plo, phi;
		logic [79:0] v;
		if (!sr || !er) return '0;
		ee = {1'b0, e};
		if (vbits_q >= 1 && vbits_q <= 63) begin
			mask = (64'd1 << vbits_q) - 64'd1;
			s = s & mask;
			ee = {1'b0, e & mask};
			if (ee[63:0] < s) ee = ee + (65'd1 << vbits_q);
		end
		if (ee <= {1'b0, s}) return '0;
		d = ee[63:0] - s;
		plo = {32'd0, d[31:0]} * {40'd0, tick_q};
		phi = {32'd0, d[63:32]} * {40'd0, tick_q};
		if (phi >= 64'h1_0000_0000) return NS48_MAX;
		v = ({16'd0, phi} << 16) + {16'd0, plo >> 16};
		return (v > {32'd0, NS48_MAX}) ? NS48_MAX : v[47:0];
	endfunction

	function automatic logic record_pair(logic [63:0] s, logic [63:0] e, logic sr, logic er);
		int idx;
		logic [31:0] age;
		idx = serial % NSLOT;
		if (!(sv[idx] && sown[idx] == serial)) begin
			if (sv[idx]) begin
				age = (serial > sown[idx]) ? serial - sown[idx] : 32'hFFFF_FFFF;
				if (age < LAG) return 1'b0;
			end
			sv[idx] = 1'b1;
			sown[idx] = serial;
			scnt[idx] = '0;
			sns[idx] = '0;
		end
		if (scnt[idx] + 1 > NPAIR) return 1'b0;
		scnt[idx] = scnt[idx] + 7'd1;
		sns[idx] = sat48({1'b0, sns[idx]} + stamp_ns(s, e, sr, er));
		return 1'b1;
	endfunction

	function automatic void close_frame(logic [31:0] now);
		logic [31:0] cpu, dt, el, rs;
		logic [47:0] g;
		logic [63:0] usage, gus;
		int idx;
		cpu = FIRST_CPU_MS;
		g = '0;
		if (seen) begin
			dt = now - last_ms;
			cpu = (dt == 0 || dt[31]) ? 32'd1 : dt;
		end else begin
			win_start = now;
		end
		last_ms = now;
		seen = 1'b1;
		if (serial >= LAG) begin
			rs = serial - LAG;
			idx = rs % NSLOT;
			if (sv[idx] && sown[idx] == rs) begin
				g = sns[idx];
				sv[idx] = 1'b0;
				scnt[idx] = '0;
				sns[idx] = '0;
			end
		end
		cpu_sum = (cpu_sum > 32'hFFFF_FFFF - cpu) ? 32'hFFFF_FFFF : cpu_sum + cpu;
		gpu_sum = sat48({1'b0, gpu_sum} + g);
		if (frame_sum != 32'hFFFF_FFFF) frame_sum = frame_sum + 32'd1;
		el = now - win_start;
		if (!el[31] && el >= win_q && cpu_sum > 0 && frame_sum > 0) begin
			usage = ({16'd0, gpu_sum} * 64'd256) / ({32'd0, cpu_sum} * 64'd10000);
			gus = {16'd0, gpu_sum} / ({32'd0, frame_sum} * 64'd1000);
			if (usage > 64'(USAGE_MAX)) usage = 64'(USAGE_MAX);
			if (gus > 64'hFFFF_FFFF) gus = 64'hFFFF_FFFF;
			if (!have) begin
				sm_usage = usage[15:0];
				sm_gpu = gus[31:0];
			end else begin
				sm_usage = 16'(({48'd0, sm_usage} + usage) >> 1);
				sm_gpu = 32'(({32'd0, sm_gpu} + gus) >> 1);
			end
			have = 1'b1;
			cpu_sum = '0;
			gpu_sum = '0;
			frame_sum = '0;
			win_start = now;
		end
		serial = serial + 32'd1;
	endfunction

	task automatic send_request(logic cmd, logic [63:0] s, logic [63:0] e,
		logic sr, logic er, logic [31:0] now);
		result_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) @(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'd0, now, er, sr, e, s};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r.taken = 1'b0;
		if (!cmd) r.taken = record_pair(s, e, sr, er);
		else close_frame(now);
		r.metrics = have;
		r.usage = sm_usage;
		r.gpu_us = sm_gpu;
		expected_q = {expected_q, r};
		sent++;
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
		while (expected_q.size() != 0) @(negedge clk);
		repeat (130) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TICK_PERIOD) tick_q = val[23:0];
		else if (idx == REG_VALID_BITS) vbits_q = val[6:0];
		else if (idx == REG_WINDOW_MS) win_q = val[15:0];
	endtask

	// receiver stall pattern
	always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[15:0], m_tdata[47:16], m_tdata[48]};
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected v%0b u%0d g%0d t%0b, got v%0b u%0d g%0d t%0b",
							want.metrics, want.usage, want.gpu_us, want.taken,
							got.metrics, got.usage, got.gpu_us, got.taken);
				end
			end
		end
	end

	logic [31:0] wall_ms;

	task automatic random_frame(int max_pairs);
		int n;
		logic [63:0] s, d;
		n = $urandom_range(max_pairs);
		for (int i = 0; i < n; i++) begin
			s = {$urandom, $urandom};
			case ($urandom_range(3))
				0: d = {$urandom, $urandom};
				1: d = 64'($urandom_range(100000));
				default: d = 64'($urandom_range(1000000));
			endcase
			send_request(1'b0, s, s + d, $urandom_range(15) != 0,
				$urandom_range(15) != 0, $urandom);
		end
		case ($urandom_range(19))
			0: wall_ms = wall_ms - $urandom_range(20);
			1: wall_ms = $urandom;
			default: wall_ms = wall_ms + $urandom_range(40);
		endcase
		send_request(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom),
			1'($urandom), wall_ms);
	endtask

	task automatic test_directed;
		send_request(1'b0, 64'd100, 64'd1100, 1'b1, 1'b1, 32'd0);
		send_request(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_request(1'b0, 64'd10, 64'd5, 1'b1, 1'b1, 32'd0);
		send_request(1'b0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 32'd0);
		send_request(1'b0, 64'd0, 64'd500, 1'b0, 1'b1, 32'd0);
		send_request(1'b0, 64'd0, 64'd500, 1'b1, 1'b0, 32'd0);
		send_request(1'b1, 64'd0, 64'd0, 1'b0, 1'b0, 32'd1000);
		send_request(1'b1, 64'd0, 64'd0, 1'b0, 1'b0, 32'd1000);
		send_request(1'b1, 64'd0, 64'd0, 1'b0, 1'b0, 32'd990);
		send_request(1'b1, 64'd0, 64'd0, 1'b0, 1'b0, 32'd1600);
		send_request(1'b1, 64'd0, 64'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
	endtask

	task automatic test_slot_full;
		for (int i = 0; i < NPAIR + 2; i++)
			send_request(1'b0, 64'd0, 64'hFFFF_FFFF, 1'b1, 1'b1, 32'd0);
		for (int i = 0; i < 4; i++) begin
			wall_ms = wall_ms + 32'd16;
			send_request(1'b1, 64'd0, 64'd0, 1'b0, 1'b0, wall_ms);
		end
	endtask

	task automatic test_config_sweep;
		write_reg(REG_VALID_BITS, 24'd8);
		write_reg(REG_TICK_PERIOD, 24'hFFFFFF);
		write_reg(REG_WINDOW_MS, 24'd0);
		send_request(1'b0, 64'h1F0, 64'h110, 1'b1, 1'b1, 32'd0);
		send_request(1'b0, 64'h110, 64'h1F0, 1'b1, 1'b1, 32'd0);
		repeat (4) random_frame(3);
		write_reg(REG_VALID_BITS, 24'd0);
		write_reg(REG_TICK_PERIOD, 24'd0);
		write_reg(REG_WINDOW_MS, 24'hFFFF);
		repeat (4) random_frame(3);
		write_reg(REG_VALID_BITS, 24'd1);
		write_reg(REG_TICK_PERIOD, 24'd1);
		repeat (3) random_frame(3);
		write_reg(REG_VALID_BITS, 24'd127);
		write_reg(REG_TICK_PERIOD, 24'd65536);
		write_reg(REG_WINDOW_MS, 24'd50);
	endtask

	task automatic test_random(int items);
		int start;
		start = sent;
		while (sent - start < items) begin
			if ($urandom_range(29) == 0) begin
				write_reg(REG_TICK_PERIOD, CFG_DW'($urandom_range(1, 24'hFFFFFF)));
				write_reg(REG_VALID_BITS, CFG_DW'($urandom_range(1, 64)));
				write_reg(REG_WINDOW_MS, CFG_DW'($urandom_range(1, 200)));
			end
			random_frame(8);
		end
	endtask

	initial begin
		tick_q = TICK_RESET; vbits_q = VBITS_RESET; win_q = WINDOW_RESET;
		serial = '0; last_ms = '0; win_start = '0; cpu_sum = '0; frame_sum = '0;
		seen = 1'b0; have = 1'b0; gpu_sum = '0; sm_usage = '0; sm_gpu = '0;
		for (int i = 0; i < NSLOT; i++) begin
			sv[i] = 1'b0; sown[i] = '0; scnt[i] = '0; sns[i] = '0;
		end
		wall_ms = 32'd5000;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed;
		test_slot_full;
		test_config_sweep;
		send_idle = 22; recv_idle = 71;
		test_random(450);
		send_idle = 71; recv_idle = 22;
		test_random(450);
		send_idle = 0; recv_idle = 0;
		test_random(400);
		while (expected_q.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire

FILE: frame_gpu_utilization_monitor.f
+incdir+hdl
hdl/fgum_pkg.sv
hdl/fgum_dp.sv
hdl/fgum_ctrl.sv
hdl/frame_gpu_utilization_monitor.sv
verif/tb_frame_gpu_utilization_monitor.sv
